// ----- design/tpm_pkg.sv -----
// shared types, constants and helpers for the two-level page table mapper
package tpm_pkg;

   localparam int PAGE_W    = 20;
   localparam int DIR_W     = 10;
   localparam int IDX_W     = 10;
   localparam int WORD_W    = 32;
   localparam int SLOT_OUT_W = 5;
   localparam int DIR_ENTRIES = 1 << DIR_W;
   localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [PAGE_W-1:0]     page_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [1:0]            op_type;
   typedef logic [SLOT_OUT_W-1:0] slot_out_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   // operation codes
   localparam op_type OP_BEGIN = 2'd0;
   localparam op_type OP_MAP   = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   // register index taken from paddr[2]
   localparam logic CSR_POOL_BASE_IDX = 1'b0;

   // present + read/write flags of every entry
   localparam logic [11:0] ENTRY_FLAGS = 12'h003;

   typedef enum logic [3:0] {
      ST_CLR_DIR,
      ST_IDLE,
      ST_DIR_RD,
      ST_DIR_CHK,
      ST_TBL_CLR,
      ST_TBL_WR,
      ST_TBL_RD,
      ST_TBL_CHK,
      ST_DONE
   } state_type;

   function automatic word_type make_word(input page_type frame);
      make_word = {frame, ENTRY_FLAGS};
   endfunction

endpackage

// ----- design/tpm_ram.sv -----
// generic simple dual-port ram with registered read
module tpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/two_level_page_table_mapper.sv -----
// top level: two-level page table builder with directory and table rams
// The block builds 32-bit two-level page tables one transaction at a time.
// Operation 0 (begin) sets the current page, 1 (map) installs a frame at the
// current page and advances it, 2 (read) reports any page; every transaction
// returns one response with both words of the reported page. After reset the
// block sweeps the directory ram clear with req_ready low. A map that
// allocates a new pool table also sweeps that table clear. The sequencer
// steps through the directory ram and then the table ram, each one access
// per cycle with a registered read. req_ready is high only while the
// sequencer is idle; the response sits in its own output register so the
// next transaction can be accepted while it waits. When the pool of
// POOL_TABLES tables runs out, a sticky halted flag is set: maps then change
// nothing and report status 1; only reset clears it.
module two_level_page_table_mapper #(
   parameter int POOL_TABLES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tpm_pkg::op_type        req_operation,
   input  tpm_pkg::page_type      req_virtual_page,
   input  tpm_pkg::page_type      req_physical_frame,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_status,
   output tpm_pkg::word_type      rsp_directory_word,
   output tpm_pkg::word_type      rsp_table_word,
   output tpm_pkg::slot_out_type  rsp_table_slot,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  tpm_pkg::csr_addr_type  csr_paddr,
   input  tpm_pkg::csr_data_type  csr_pwdata,
   output tpm_pkg::csr_data_type  csr_prdata,
   output logic                   csr_pready
);

   import tpm_pkg::*;

   localparam int SLOT_W  = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int USED_W  = $clog2(POOL_TABLES + 1);
   localparam int TBL_DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
   localparam int TBL_AW  = $clog2(TBL_DEPTH);
   localparam int DIR_DW  = SLOT_W + 1;

   // sequencer
   state_type state_ff, state_in;

   // transaction context
   page_type            page_ff, page_in;        // page being reported or mapped
   page_type            frame_ff, frame_in;
   logic                is_map_ff, is_map_in;    // live map (not halted)
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                res_present_ff, res_present_in;
   word_type            res_table_ff, res_table_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;          // clearing sweep index

   // architectural state
   page_type            current_page_ff, current_page_in;
   logic [USED_W-1:0]   tables_used_ff, tables_used_in;
   logic                halted_ff, halted_in;
   page_type            pool_base_ff, pool_base_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   word_type            rsp_dir_ff, rsp_dir_in;
   word_type            rsp_tbl_ff, rsp_tbl_in;
   slot_out_type        rsp_slot_ff, rsp_slot_in;

   // ram ports
   logic                dir_we;
   logic [DIR_W-1:0]    dir_waddr;
   logic [DIR_DW-1:0]   dir_wdata;
   logic [DIR_DW-1:0]   dir_rdata;
   logic                tbl_we;
   logic [TBL_AW-1:0]   tbl_waddr;
   word_type            tbl_wdata;
   logic [TBL_AW-1:0]   tbl_raddr;
   word_type            tbl_rdata;

   logic                accept;
   logic                out_load;
   logic                dir_present;
   logic [SLOT_W-1:0]   dir_slot;
   logic                pool_full;
   logic                csr_write;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   // the output register takes a new response once the old one is gone
   assign out_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign dir_present = dir_rdata[SLOT_W];
   assign dir_slot    = dir_rdata[SLOT_W-1:0];
   assign pool_full   = (tables_used_ff == USED_W'(POOL_TABLES));
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // directory: present flag and pool slot per directory index
   tpm_ram #(
      .WIDTH (DIR_DW),
      .DEPTH (DIR_ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_addr (page_ff[PAGE_W-1 -: DIR_W]),
      .rd_data (dir_rdata)
   );

   // pool of page tables, one 1024-entry row per slot
   tpm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TBL_DEPTH)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign tbl_raddr = TBL_AW'({slot_ff, page_ff[IDX_W-1:0]});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR_DIR: begin
            if (cnt_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_DIR_RD;
         end
         ST_DIR_RD: state_in = ST_DIR_CHK;
         ST_DIR_CHK: begin
            if (is_map_ff) begin
               if (dir_present)    state_in = ST_TBL_WR;
               else if (pool_full) state_in = ST_DONE;
               else                state_in = ST_TBL_CLR;
            end else begin
               state_in = dir_present ? ST_TBL_RD : ST_DONE;
            end
         end
         ST_TBL_CLR: begin
            if (cnt_ff == '1) state_in = ST_TBL_WR;
         end
         ST_TBL_WR:  state_in = ST_DONE;
         ST_TBL_RD:  state_in = ST_TBL_CHK;
         ST_TBL_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLR_DIR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      page_in         = page_ff;
      frame_in        = frame_ff;
      is_map_in       = is_map_ff;
      slot_in         = slot_ff;
      res_present_in  = res_present_ff;
      res_table_in    = res_table_ff;
      cnt_in          = cnt_ff;
      current_page_in = current_page_ff;
      tables_used_in  = tables_used_ff;
      halted_in       = halted_ff;
      dir_we          = 1'b0;
      dir_waddr       = cnt_ff;
      dir_wdata       = '0;
      tbl_we          = 1'b0;
      tbl_waddr       = TBL_AW'({slot_ff, cnt_ff});
      tbl_wdata       = '0;

      case (state_ff)
         ST_CLR_DIR: begin
            // sweep every directory entry to absent
            dir_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               frame_in  = req_physical_frame;
               is_map_in = (req_operation == OP_MAP) && !halted_ff;
               if (req_operation == OP_BEGIN) begin
                  page_in         = req_virtual_page;
                  current_page_in = req_virtual_page;
               end else if (req_operation == OP_READ) begin
                  page_in = req_virtual_page;
               end else begin
                  page_in = current_page_ff;
               end
            end
         end
         ST_DIR_CHK: begin
            slot_in = dir_slot;
            if (is_map_ff && !dir_present) begin
               if (pool_full) begin
                  // pool exhausted: halt, report the page as absent
                  halted_in      = 1'b1;
                  res_present_in = 1'b0;
               end else begin
                  // allocate the next pool table for this directory index
                  dir_we         = 1'b1;
                  dir_waddr      = page_ff[PAGE_W-1 -: DIR_W];
                  dir_wdata      = {1'b1, tables_used_ff[SLOT_W-1:0]};
                  slot_in        = tables_used_ff[SLOT_W-1:0];
                  tables_used_in = tables_used_ff + 1'b1;
                  cnt_in         = '0;
               end
            end else if (!is_map_ff && !dir_present) begin
               res_present_in = 1'b0;
            end
         end
         ST_TBL_CLR: begin
            tbl_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_TBL_WR: begin
            tbl_we          = 1'b1;
            tbl_waddr       = TBL_AW'({slot_ff, page_ff[IDX_W-1:0]});
            tbl_wdata       = make_word(frame_ff);
            res_present_in  = 1'b1;
            res_table_in    = make_word(frame_ff);
            current_page_in = page_ff + 1'b1;
         end
         ST_TBL_CHK: begin
            res_present_in = 1'b1;
            res_table_in   = tbl_rdata;
         end
         default: begin
         end
      endcase
   end

   // response formation; directory word uses the pool base as it is now
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_tbl_in    = rsp_tbl_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = halted_ff;
         if (res_present_ff) begin
            rsp_dir_in  = make_word(PAGE_W'(pool_base_ff + PAGE_W'(slot_ff)));
            rsp_tbl_in  = res_table_ff;
            rsp_slot_in = SLOT_OUT_W'(slot_ff);
         end else begin
            rsp_dir_in  = '0;
            rsp_tbl_in  = '0;
            rsp_slot_in = '0;
         end
      end
   end

   // register port
   always_comb begin
      pool_base_in = pool_base_ff;
      if (csr_write && (csr_paddr[2] == CSR_POOL_BASE_IDX)) begin
         pool_base_in = csr_pwdata[PAGE_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_POOL_BASE_IDX) ?
                       CSR_DATA_W'(pool_base_ff) : '0;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLR_DIR;
         cnt_ff          <= '0;
         current_page_ff <= '0;
         tables_used_ff  <= '0;
         halted_ff       <= 1'b0;
         pool_base_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         current_page_ff <= current_page_in;
         tables_used_ff  <= tables_used_in;
         halted_ff       <= halted_in;
         pool_base_ff    <= pool_base_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      frame_ff       <= frame_in;
      is_map_ff      <= is_map_in;
      slot_ff        <= slot_in;
      res_present_ff <= res_present_in;
      res_table_ff   <= res_table_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_tbl_ff     <= rsp_tbl_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_directory_word = rsp_dir_ff;
   assign rsp_table_word     = rsp_tbl_ff;
   assign rsp_table_slot     = rsp_slot_ff;

endmodule

// ----- design/tpm_checker.sv -----
// port-level assertions for the page table mapper, bound to the top level
module tpm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input tpm_pkg::op_type        req_operation,
   input tpm_pkg::page_type      req_virtual_page,
   input tpm_pkg::page_type      req_physical_frame,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_status,
   input tpm_pkg::word_type      rsp_directory_word,
   input tpm_pkg::word_type      rsp_table_word,
   input tpm_pkg::slot_out_type  rsp_table_slot,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input tpm_pkg::csr_addr_type  csr_paddr,
   input tpm_pkg::csr_data_type  csr_pwdata,
   input tpm_pkg::csr_data_type  csr_prdata,
   input logic                   csr_pready
);

   import tpm_pkg::*;

   // a delivered halted status stays halted until reset
   logic seen_halt_ff, seen_halt_in;

   assign seen_halt_in = seen_halt_ff || (rsp_valid && rsp_ready && rsp_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else begin
         seen_halt_ff <= seen_halt_in;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_directory_word)
         && $stable(rsp_table_word) && $stable(rsp_status))
      else $error("response changed while stalled");

   // ready drops after an accept, so no two transactions are accepted back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready still high after accept");

   // halt is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_halt_ff |-> rsp_status)
      else $error("halted status cleared without reset");

   // an absent directory entry reports all zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_directory_word[1:0] != ENTRY_FLAGS[1:0]) |->
         (rsp_directory_word == '0) && (rsp_table_word == '0)
         && (rsp_table_slot == '0))
      else $error("absent directory entry with nonzero fields");

   // a nonzero table word always carries the entry flags
   a_table_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_table_word != '0) |->
         (rsp_table_word[11:0] == ENTRY_FLAGS))
      else $error("table word without entry flags");

endmodule

bind two_level_page_table_mapper tpm_checker u_tpm_checker (.*);

// ----- test/page_map_checker.sv -----
// checker for the page table mapper: predicts every response and compares it
`timescale 1ns / 100ps
module page_map_checker #(
   parameter int POOL_TABLES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  tpm_pkg::op_type       req_operation,
   input  tpm_pkg::page_type     req_virtual_page,
   input  tpm_pkg::page_type     req_physical_frame,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_status,
   input  tpm_pkg::word_type     rsp_directory_word,
   input  tpm_pkg::word_type     rsp_table_word,
   input  tpm_pkg::slot_out_type rsp_table_slot,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  tpm_pkg::csr_addr_type csr_paddr,
   input  tpm_pkg::csr_data_type csr_pwdata,
   output int                    failures,
   output int                    responses_checked,
   output int                    pending_count
);
   import tpm_pkg::*;

   localparam csr_addr_type POOL_BASE_ADDR = csr_addr_type'(4 * int'(CSR_POOL_BASE_IDX));

   typedef struct packed {
      logic         status;
      word_type     directory_word;
      word_type     table_word;
      slot_out_type table_slot;
   } page_report_t;

   page_report_t expected_reports[$];

   // shadow of the mapper state
   page_type pool_base;
   page_type cur_page;
   int       tables_used;
   bit       halted;
   bit       dir_present [DIR_ENTRIES];
   int       dir_slot    [DIR_ENTRIES];
   word_type table_mem   [POOL_TABLES*ENTRIES_PER_TABLE];

   int fail_count = 0;
   int rsp_count  = 0;

   function automatic word_type entry_word(page_type frame);
      return {frame, ENTRY_FLAGS};
   endfunction

   function automatic page_report_t describe_page(page_type page);
      page_report_t rep;
      int dir;
      int slot;
      dir = int'(page[PAGE_W-1:IDX_W]);
      rep.status = halted;
      if (dir_present[dir]) begin
         slot = dir_slot[dir];
         rep.directory_word = entry_word(pool_base + page_type'(slot));
         rep.table_word     = table_mem[slot*ENTRIES_PER_TABLE + int'(page[IDX_W-1:0])];
         rep.table_slot     = slot_out_type'(slot);
      end else begin
         rep.directory_word = '0;
         rep.table_word     = '0;
         rep.table_slot     = '0;
      end
      return rep;
   endfunction

   function automatic void install_frame(page_type frame);
      int dir;
      int idx;
      int slot;
      dir = int'(cur_page[PAGE_W-1:IDX_W]);
      idx = int'(cur_page[IDX_W-1:0]);
      if (halted) return;
      if (!dir_present[dir]) begin
         // pool exhausted: halt and leave everything else alone
         if (tables_used >= POOL_TABLES) begin
            halted = 1'b1;
            return;
         end
         slot = tables_used;
         tables_used++;
         for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            table_mem[slot*ENTRIES_PER_TABLE + i] = '0;
         dir_slot[dir]    = slot;
         dir_present[dir] = 1'b1;
      end
      slot = dir_slot[dir];
      table_mem[slot*ENTRIES_PER_TABLE + idx] = entry_word(frame);
   endfunction

   function automatic page_report_t apply_request(op_type op, page_type vpage,
                                                 page_type frame);
      page_report_t rep;
      page_type     mapped_page;
      bit           was_halted;
      case (op)
         OP_BEGIN: begin
            cur_page = vpage;
            rep = describe_page(cur_page);
         end
         OP_MAP: begin
            mapped_page = cur_page;
            was_halted  = halted;
            install_frame(frame);
            rep = describe_page(mapped_page);
            if (!was_halted && !halted) cur_page = cur_page + 1'b1;
         end
         OP_READ: rep = describe_page(vpage);
         default: rep = describe_page(cur_page);
      endcase
      return rep;
   endfunction

   function automatic int field_mismatch(string name, logic [31:0] want_v,
                                         logic [31:0] got_v);
      if (got_v === want_v) return 0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      return 1;
   endfunction

   always @(posedge clock) begin
      page_report_t want;
      if (reset) begin
         pool_base   = '0;
         cur_page    = '0;
         tables_used = 0;
         halted      = 1'b0;
         foreach (dir_present[i]) dir_present[i] = 1'b0;
         foreach (dir_slot[i]) dir_slot[i] = 0;
         foreach (table_mem[i]) table_mem[i] = '0;
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == POOL_BASE_ADDR)
            pool_base = csr_pwdata[PAGE_W-1:0];
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h %h %h %h",
                        $time, rsp_status, rsp_directory_word, rsp_table_word,
                        rsp_table_slot);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               fail_count += field_mismatch("status", 32'(want.status), 32'(rsp_status));
               fail_count += field_mismatch("directory_word", want.directory_word,
                                            rsp_directory_word);
               fail_count += field_mismatch("table_word", want.table_word, rsp_table_word);
               fail_count += field_mismatch("table_slot", 32'(want.table_slot),
                                            32'(rsp_table_slot));
            end
         end
         if (req_valid && req_ready)
            expected_reports.push_back(apply_request(req_operation, req_virtual_page,
                                                     req_physical_frame));
      end
      failures          <= fail_count;
      responses_checked <= rsp_count;
      pending_count     <= expected_reports.size();
   end

endmodule

// ----- test/tb.sv -----
// testbench top for the two-level page table mapper: stimulus and verdict
`timescale 1ns / 100ps
module tb;
   import tpm_pkg::*;

   localparam int POOL_TABLES = 32;
   localparam csr_addr_type POOL_BASE_ADDR = csr_addr_type'(4 * int'(CSR_POOL_BASE_IDX));
   // the op code the block does not define
   localparam op_type OP_UNUSED = 2'd3;
   // quiet time after the last response
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PER_PHASE = 240;
   localparam int PHASES = 5;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   op_type       req_operation = OP_BEGIN;
   page_type     req_virtual_page = '0;
   page_type     req_physical_frame = '0;

   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic         rsp_status;
   word_type     rsp_directory_word;
   word_type     rsp_table_word;
   slot_out_type rsp_table_slot;

   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   csr_addr_type csr_paddr = '0;
   csr_data_type csr_pwdata = '0;
   csr_data_type csr_prdata;
   logic         csr_pready;

   int failures;
   int responses_checked;
   int pending_count;

   // accepted request transactions, compared against the checker's response count
   int sent_count = 0;

   // idling controls: switched off now and then for back-to-back stretches
   bit req_idle_on = 1'b1;
   bit rsp_stall_on = 1'b1;
   int rsp_stall_left = 0;

   // stimulus shaping: a few home directories keep the pool from running dry early,
   // and recently mapped pages are read back
   logic [DIR_W-1:0] home_dirs [8];
   page_type         recent_pages [16];
   int               recent_wr = 0;
   page_type         track_page = '0;

   two_level_page_table_mapper #(
      .POOL_TABLES(POOL_TABLES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_virtual_page  (req_virtual_page),
      .req_physical_frame(req_physical_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_directory_word(rsp_directory_word),
      .rsp_table_word    (rsp_table_word),
      .rsp_table_slot    (rsp_table_slot),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   page_map_checker #(
      .POOL_TABLES(POOL_TABLES)
   ) mapping_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_virtual_page  (req_virtual_page),
      .req_physical_frame(req_physical_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_directory_word(rsp_directory_word),
      .rsp_table_word    (rsp_table_word),
      .rsp_table_slot    (rsp_table_slot),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .failures          (failures),
      .responses_checked (responses_checked),
      .pending_count     (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run (32 table clears included)
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // idle length: mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 2);
      if (r < 90) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // frame numbers lean on the all-zero and all-one extremes
   function automatic page_type rand_frame();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return page_type'($urandom);
      endcase
   endfunction

   // where a run of maps starts: near the end of a home directory now and then,
   // so the run can spill into the next directory and allocate a table
   function automatic page_type start_page(bit wide);
      logic [DIR_W-1:0] dir;
      logic [IDX_W-1:0] idx;
      int               k;
      if (wide) return page_type'($urandom);
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 4) == 0) begin
         dir = home_dirs[k];
         idx = IDX_W'($urandom_range(1012, 1023));
      end else begin
         dir = home_dirs[k] + DIR_W'($urandom_range(0, 1));
         idx = IDX_W'($urandom);
      end
      return {dir, idx};
   endfunction

   // response side back-pressure, independent of what the block is doing
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_stall_on && $urandom_range(0, 99) < 30) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request transaction; valid stays high straight into the next one when
   // there is no gap, so it is never dropped and raised in the same step
   task automatic send_item(op_type op, page_type vpage, page_type frame);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 99) >= 40) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_virtual_page   <= vpage;
      req_physical_frame <= frame;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      // rough page tracking, only to aim read-backs at mapped pages
      if (op == OP_BEGIN) begin
         track_page = vpage;
      end else if (op == OP_MAP) begin
         recent_pages[recent_wr] = track_page;
         recent_wr  = (recent_wr + 1) % 16;
         track_page = track_page + 1'b1;
      end
   endtask

   // setup cycle then access cycle; the write lands on the access edge
   task automatic write_pool_base(csr_data_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= POOL_BASE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait for every accepted transaction to come back, then let the block settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (responses_checked != sent_count) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_traffic(int count, bit wide);
      int done_items;
      int choice;
      int run;
      done_items = 0;
      while (done_items < count) begin
         // now and then switch idling on or off on either side
         if ($urandom_range(0, 49) == 0) begin
            req_idle_on  = ($urandom_range(0, 2) != 0);
            rsp_stall_on <= ($urandom_range(0, 2) != 0);
         end
         choice = $urandom_range(0, 99);
         if (choice < 18) begin
            // well-formed run: begin somewhere, then a burst of maps
            run = $urandom_range(1, 8);
            send_item(OP_BEGIN, start_page(wide), rand_frame());
            repeat (run) send_item(OP_MAP, page_type'($urandom), rand_frame());
            done_items += run + 1;
         end else begin
            if (choice < 50)
               send_item(OP_MAP, page_type'($urandom), rand_frame());
            else if (choice < 78)
               send_item(OP_READ, recent_pages[$urandom_range(0, 15)], rand_frame());
            else if (choice < 90)
               send_item(OP_READ, page_type'($urandom), rand_frame());
            else if (choice < 95)
               send_item(OP_READ, start_page(1'b0), rand_frame());
            else
               send_item(OP_UNUSED, page_type'($urandom), page_type'($urandom));
            done_items++;
         end
      end
   endtask

   initial begin
      csr_data_type pool_settings [PHASES];
      // extremes first: top frame (slot 1 wraps to frame 0), zero, highest legal base,
      // garbage in the upper bits, then an ordinary value
      pool_settings = '{32'h000F_FFFF, 32'h0000_0000, 32'h000F_FFE0, $urandom,
                        32'($urandom_range(0, 20'hFFFFF))};
      foreach (home_dirs[k]) home_dirs[k] = DIR_W'($urandom_range(2, 1020));
      foreach (recent_pages[k]) recent_pages[k] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directory clearing sweep after reset keeps req_ready low
      do @(posedge clock); while (req_ready !== 1'b1);
      write_pool_base(pool_settings[0]);

      // directed: empty lookups at both ends of the address space
      send_item(OP_READ, '0, '0);
      send_item(OP_READ, '1, '1);
      // last page of the last directory, then the page counter wraps to 0
      send_item(OP_BEGIN, '1, '0);
      send_item(OP_MAP, '0, '1);
      send_item(OP_MAP, '1, '0);
      send_item(OP_MAP, 20'h55555, 20'hAAAAA);
      send_item(OP_MAP, 20'hAAAAA, 20'h55555);
      send_item(OP_READ, '1, '0);
      send_item(OP_READ, 20'h00000, '1);
      send_item(OP_READ, 20'h00002, 20'h00000);
      // present directory, entry never written
      send_item(OP_READ, 20'h00003, 20'hFFFFF);
      send_item(OP_UNUSED, 20'h12345, 20'h6789A);
      // run across a directory boundary: second map allocates a fresh table
      send_item(OP_BEGIN, 20'h003FF, '0);
      send_item(OP_MAP, '0, 20'h12345);
      send_item(OP_MAP, '1, 20'hFEDCB);
      send_item(OP_READ, 20'h003FF, '0);
      send_item(OP_READ, 20'h00400, '0);
      send_item(OP_BEGIN, 20'hAAAAA, 20'h55555);
      send_item(OP_BEGIN, 20'h55555, 20'hAAAAA);
      send_item(OP_UNUSED, '1, '1);
      send_item(OP_MAP, 20'hAAAAA, 20'h0F0F0);
      send_item(OP_READ, 20'h55555, '0);

      // random phases; the last one starts its runs anywhere in the page space
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain_responses();
            write_pool_base(pool_settings[phase]);
         end
         random_traffic(RANDOM_PER_PHASE, phase == PHASES - 1);
      end

      // forty distinct directories guarantee the pool runs out
      req_idle_on  = 1'b1;
      rsp_stall_on <= 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_item(OP_BEGIN, {DIR_W'(i * 25 + 3), IDX_W'($urandom)}, rand_frame());
         send_item(OP_MAP, page_type'($urandom), rand_frame());
      end
      // halted: maps are refused, begin and read keep working
      send_item(OP_MAP, '1, '1);
      send_item(OP_BEGIN, '0, '0);
      send_item(OP_MAP, '0, '0);
      send_item(OP_READ, '1, '0);
      send_item(OP_UNUSED, '0, '1);

      drain_responses();
      if (failures == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tpm_pkg.sv
design/tpm_ram.sv
design/two_level_page_table_mapper.sv
design/tpm_checker.sv
test/page_map_checker.sv
test/tb.sv
